### rtl/number_to_radix_text_macros.svh
`ifndef NUMBER_TO_RADIX_TEXT_MACROS_SVH
`define NUMBER_TO_RADIX_TEXT_MACROS_SVH

// same-cycle implication on clk, quiet during rst
`define NTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, quiet during rst
`define NTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ntr_pkg.sv
package ntr_pkg;

  localparam int INT_W = 32;
  localparam int FRAC_IN_W = 32;
  localparam int FRAC_BITS = 32;
  localparam int MAX_FRAC_DIGITS = 15;
  localparam int RADIX_W = 5;
  localparam int NDIG_W = 4;
  localparam int CHAR_W = 8;
  localparam int DIGIT_W = 4;
  localparam int MAX_INT_DIGITS = INT_W;
  localparam int IDX_W = $clog2(MAX_INT_DIGITS);
  localparam int NINT_W = IDX_W + 1;
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS = INT_W / BITS_PER_STEP;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam int PROD_W = FRAC_BITS + RADIX_W;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h37;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_N = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_A = 8'h61;

  typedef struct packed {
    logic nan;
    logic minus;
    logic [INT_W-1:0] ipart;
    logic [FRAC_BITS-1:0] frac;
    logic [RADIX_W-1:0] radix;
    logic [NDIG_W-1:0] ndig;
  } entry_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic last;
  } text_t;

  function automatic logic [CHAR_W-1:0] digit_sym(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_W'(10)) begin
      return CH_ZERO + CHAR_W'(d);
    end
    return CH_ALPHA + CHAR_W'(d);
  endfunction

endpackage

### rtl/number_to_radix_text.sv
// the first char reaches the outputs once the integer and fraction digits are computed;
// a nan skips both loops. One number is converted at a time; the two-entry input queue
// holds new requests meanwhile. The integer loop (eight division bits per cycle) divides
// the whole integer once per digit and takes the most time, above all in binary
// rst (synchronous) empties both queues and returns the sequencer to idle
module number_to_radix_text (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic is_negative,
  input  logic [ntr_pkg::INT_W-1:0] integer_magnitude,
  input  logic [ntr_pkg::FRAC_IN_W-1:0] fraction_magnitude,
  input  logic [ntr_pkg::RADIX_W-1:0] radix,
  input  logic signed_mode,
  input  logic [ntr_pkg::NDIG_W-1:0] frac_digits,
  output logic empty,
  input  logic pop,
  output logic [ntr_pkg::CHAR_W-1:0] char_out,
  output logic last_char
);

  logic head_valid;
  logic head_take;
  ntr_pkg::entry_t head;
  logic emit_valid;
  logic emit_room;
  ntr_pkg::text_t emit_text;

  ntr_front u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .is_negative(is_negative),
    .integer_magnitude(integer_magnitude),
    .fraction_magnitude(fraction_magnitude),
    .radix(radix),
    .signed_mode(signed_mode),
    .frac_digits(frac_digits),
    .head_valid(head_valid),
    .head(head),
    .head_take(head_take)
  );

  ntr_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head(head),
    .head_take(head_take),
    .emit_valid(emit_valid),
    .emit_text(emit_text),
    .emit_room(emit_room)
  );

  ntr_outq u_outq (
    .clk(clk),
    .rst(rst),
    .in_valid(emit_valid),
    .in_text(emit_text),
    .room(emit_room),
    .empty(empty),
    .pop(pop),
    .char_out(char_out),
    .last_char(last_char)
  );

endmodule

### rtl/ntr_front.sv
module ntr_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic is_negative,
  input  logic [ntr_pkg::INT_W-1:0] integer_magnitude,
  input  logic [ntr_pkg::FRAC_IN_W-1:0] fraction_magnitude,
  input  logic [ntr_pkg::RADIX_W-1:0] radix,
  input  logic signed_mode,
  input  logic [ntr_pkg::NDIG_W-1:0] frac_digits,
  output logic head_valid,
  output ntr_pkg::entry_t head,
  input  logic head_take
);

  ntr_pkg::entry_t q [2];
  ntr_pkg::entry_t ent;
  logic wp;
  logic rp;
  logic [1:0] count;
  logic fire_in;
  logic take;
  logic neg_eff;

  always_comb begin
    neg_eff = is_negative &&
              !(integer_magnitude == '0 && fraction_magnitude == '0);
    ent.nan = neg_eff && !signed_mode;
    ent.minus = neg_eff && signed_mode;
    ent.ipart = integer_magnitude;
    ent.frac = fraction_magnitude[ntr_pkg::FRAC_IN_W-1 -: ntr_pkg::FRAC_BITS];
    if (radix < ntr_pkg::RADIX_MIN) begin
      ent.radix = ntr_pkg::RADIX_MIN;
    end else if (radix > ntr_pkg::RADIX_MAX) begin
      ent.radix = ntr_pkg::RADIX_MAX;
    end else begin
      ent.radix = radix;
    end
    if (frac_digits > ntr_pkg::NDIG_W'(ntr_pkg::MAX_FRAC_DIGITS)) begin
      ent.ndig = ntr_pkg::NDIG_W'(ntr_pkg::MAX_FRAC_DIGITS);
    end else begin
      ent.ndig = frac_digits;
    end
  end

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head = q[rp];
  assign fire_in = push && !full;
  assign take = head_take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (fire_in) begin
        q[wp] <= ent;
        wp <= ~wp;
      end
      if (take) begin
        rp <= ~rp;
      end
      case ({fire_in, take})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/ntr_back.sv
`include "number_to_radix_text_macros.svh"

module ntr_back (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  ntr_pkg::entry_t head,
  output logic head_take,
  output logic emit_valid,
  output ntr_pkg::text_t emit_text,
  input  logic emit_room
);

  typedef enum logic [1:0] {S_IDLE, S_IDIV, S_FRAC, S_EMIT} state_t;
  typedef enum logic [2:0] {PH_NAN, PH_SIGN, PH_INT, PH_POINT, PH_FRAC} phase_t;

  state_t state;
  phase_t phase;
  ntr_pkg::entry_t cur;
  logic [ntr_pkg::INT_W-1:0] divd;
  logic [ntr_pkg::DIGIT_W-1:0] rem;
  logic [ntr_pkg::STEP_W-1:0] step;
  logic [ntr_pkg::NINT_W-1:0] nint;
  logic [ntr_pkg::DIGIT_W-1:0] istack [ntr_pkg::MAX_INT_DIGITS];
  logic [ntr_pkg::FRAC_BITS-1:0] frac;
  logic [ntr_pkg::DIGIT_W-1:0] fbuf [ntr_pkg::MAX_FRAC_DIGITS];
  logic [ntr_pkg::NDIG_W-1:0] k;
  logic [ntr_pkg::NDIG_W-1:0] flen;
  logic [ntr_pkg::IDX_W-1:0] ipos;
  logic [ntr_pkg::NDIG_W-1:0] fpos;
  logic [1:0] nidx;

  logic [ntr_pkg::DIGIT_W-1:0] rem_next;
  logic [ntr_pkg::BITS_PER_STEP-1:0] qbyte;
  logic [ntr_pkg::INT_W-1:0] divd_next;
  logic [ntr_pkg::PROD_W-1:0] prod;
  logic [ntr_pkg::DIGIT_W-1:0] fdig;
  logic [ntr_pkg::NINT_W-1:0] nint_dec;
  logic emit_fire;

  // eight restoring steps of the long division per cycle
  always_comb begin
    logic [ntr_pkg::DIGIT_W:0] t;
    logic [ntr_pkg::DIGIT_W-1:0] r;
    r = rem;
    qbyte = '0;
    for (int i = 0; i < ntr_pkg::BITS_PER_STEP; i++) begin
      t = {r, divd[ntr_pkg::INT_W-1-i]};
      if (t >= cur.radix) begin
        r = ntr_pkg::DIGIT_W'(t - cur.radix);
        qbyte[ntr_pkg::BITS_PER_STEP-1-i] = 1'b1;
      end else begin
        r = t[ntr_pkg::DIGIT_W-1:0];
      end
    end
    rem_next = r;
    divd_next = {divd[ntr_pkg::INT_W-ntr_pkg::BITS_PER_STEP-1:0], qbyte};
  end

  assign prod = ntr_pkg::PROD_W'(frac) * ntr_pkg::PROD_W'(cur.radix);
  assign fdig = prod[ntr_pkg::FRAC_BITS +: ntr_pkg::DIGIT_W];
  assign nint_dec = nint - 1'b1;

  assign head_take = (state == S_IDLE) && head_valid;
  assign emit_valid = (state == S_EMIT);
  assign emit_fire = emit_valid && emit_room;

  always_comb begin
    emit_text.ch = ntr_pkg::CH_N;
    emit_text.last = 1'b0;
    case (phase)
      PH_NAN: begin
        emit_text.ch = (nidx == 2'd1) ? ntr_pkg::CH_A : ntr_pkg::CH_N;
        emit_text.last = (nidx == 2'd2);
      end
      PH_SIGN: emit_text.ch = ntr_pkg::CH_MINUS;
      PH_INT: begin
        emit_text.ch = ntr_pkg::digit_sym(istack[ipos]);
        emit_text.last = (ipos == '0) && (flen == '0);
      end
      PH_POINT: emit_text.ch = ntr_pkg::CH_POINT;
      PH_FRAC: begin
        emit_text.ch = ntr_pkg::digit_sym(fbuf[fpos]);
        emit_text.last = (fpos == flen - 1'b1);
      end
      default: emit_text.ch = ntr_pkg::CH_N;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_NAN;
    end else begin
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur <= head;
            divd <= head.ipart;
            rem <= '0;
            step <= '0;
            nint <= '0;
            frac <= head.frac;
            k <= '0;
            flen <= '0;
            fpos <= '0;
            nidx <= 2'd0;
            if (head.nan) begin
              state <= S_EMIT;
              phase <= PH_NAN;
            end else begin
              state <= S_IDIV;
            end
          end
        end
        S_IDIV: begin
          divd <= divd_next;
          step <= step + 1'b1;
          if (step == ntr_pkg::STEP_W'(ntr_pkg::DIV_STEPS - 1)) begin
            istack[nint[ntr_pkg::IDX_W-1:0]] <= rem_next;
            nint <= nint + 1'b1;
            rem <= '0;
            if (divd_next == '0) begin
              state <= S_FRAC;
            end
          end else begin
            rem <= rem_next;
          end
        end
        S_FRAC: begin
          if (k == cur.ndig) begin
            state <= S_EMIT;
            phase <= cur.minus ? PH_SIGN : PH_INT;
            ipos <= nint_dec[ntr_pkg::IDX_W-1:0];
          end else begin
            fbuf[k] <= fdig;
            frac <= prod[ntr_pkg::FRAC_BITS-1:0];
            if (fdig != '0) begin
              flen <= k + 1'b1;
            end
            k <= k + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            case (phase)
              PH_NAN: begin
                nidx <= nidx + 2'd1;
                if (nidx == 2'd2) begin
                  state <= S_IDLE;
                end
              end
              PH_SIGN: phase <= PH_INT;
              PH_INT: begin
                if (ipos == '0) begin
                  if (flen != '0) begin
                    phase <= PH_POINT;
                  end else begin
                    state <= S_IDLE;
                  end
                end else begin
                  ipos <= ipos - 1'b1;
                end
              end
              PH_POINT: phase <= PH_FRAC;
              PH_FRAC: begin
                if (fpos == flen - 1'b1) begin
                  state <= S_IDLE;
                end else begin
                  fpos <= fpos + 1'b1;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NTR_ASSERT_NOW(a_rem_below_radix, state == S_IDIV, rem < cur.radix, "remainder not below radix")
  `NTR_ASSERT_NEXT(a_last_ends_item, emit_fire && emit_text.last, state == S_IDLE, "last char did not end item")
  `NTR_ASSERT_NOW(a_frac_in_range, state == S_EMIT && phase == PH_FRAC, fpos < flen, "fraction index past trimmed length")
  `NTR_ASSERT_NOW(a_int_digits_bound, state == S_FRAC, nint != '0 && nint <= ntr_pkg::NINT_W'(ntr_pkg::MAX_INT_DIGITS), "integer digit count out of range")

endmodule

### rtl/ntr_outq.sv
module ntr_outq (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  ntr_pkg::text_t in_text,
  output logic room,
  output logic empty,
  input  logic pop,
  output logic [ntr_pkg::CHAR_W-1:0] char_out,
  output logic last_char
);

  ntr_pkg::text_t q [2];
  logic wp;
  logic rp;
  logic [1:0] count;
  logic fire_in;
  logic take;

  assign room = (count != 2'd2);
  assign empty = (count == 2'd0);
  assign fire_in = in_valid && room;
  assign take = pop && !empty;
  assign char_out = q[rp].ch;
  assign last_char = q[rp].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (fire_in) begin
        q[wp] <= in_text;
        wp <= ~wp;
      end
      if (take) begin
        rp <= ~rp;
      end
      case ({fire_in, take})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### verif/tb.sv
class text_scoreboard;
  ntr_pkg::text_t pending[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  function logic [7:0] digit_char(input logic [3:0] d);
    string syms;
    syms = "0123456789ABCDEF";
    return syms[d];
  endfunction

  // expected text for one accepted request
  function void note_request(input logic neg_in, input logic [31:0] ipart_in,
                             input logic [31:0] frac_in, input logic [4:0] radix_in,
                             input logic sgn, input logic [3:0] ndig_in);
    logic [7:0] txt[$];
    logic [7:0] rev[$];
    logic [63:0] frac;
    logic [63:0] prod;
    logic [63:0] mask;
    logic [31:0] ipart;
    logic [31:0] base;
    logic [3:0] ndig;
    logic neg;
    ntr_pkg::text_t item;
    int i;
    neg = neg_in;
    ipart = ipart_in;
    mask = (64'd1 << ntr_pkg::FRAC_BITS) - 64'd1;
    frac = 64'(frac_in >> (ntr_pkg::FRAC_IN_W - ntr_pkg::FRAC_BITS)) & mask;
    base = 32'(radix_in);
    if (base < 32'd2) base = 32'd2;
    if (base > 32'd16) base = 32'd16;
    ndig = ndig_in;
    if (ndig > 4'(ntr_pkg::MAX_FRAC_DIGITS)) ndig = 4'(ntr_pkg::MAX_FRAC_DIGITS);
    // negative zero prints as plain zero
    if (ipart_in == 32'd0 && frac_in == 32'd0) neg = 1'b0;
    if (neg && !sgn) begin
      txt.push_back(ntr_pkg::CH_N);
      txt.push_back(ntr_pkg::CH_A);
      txt.push_back(ntr_pkg::CH_N);
    end else begin
      if (neg) txt.push_back(ntr_pkg::CH_MINUS);
      do begin
        rev.push_back(digit_char(4'(ipart % base)));
        ipart = ipart / base;
      end while (ipart != 32'd0);
      for (i = rev.size() - 1; i >= 0; i--) txt.push_back(rev[i]);
      if (ndig != 4'd0) begin
        txt.push_back(ntr_pkg::CH_POINT);
        for (i = 0; i < int'(ndig); i++) begin
          prod = frac * 64'(base);
          txt.push_back(digit_char(4'(prod >> ntr_pkg::FRAC_BITS)));
          frac = prod & mask;
        end
        // trailing zeros, then a bare point
        while (txt.size() > 0 && txt[txt.size() - 1] == ntr_pkg::CH_ZERO) void'(txt.pop_back());
        if (txt.size() > 0 && txt[txt.size() - 1] == ntr_pkg::CH_POINT) void'(txt.pop_back());
      end
    end
    for (i = 0; i < txt.size(); i++) begin
      item.ch = txt[i];
      item.last = (i == txt.size() - 1);
      pending.push_back(item);
    end
  endfunction

  task report(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task check_result(input logic [7:0] ch, input logic last);
    ntr_pkg::text_t want;
    if (pending.size() == 0) begin
      report($sformatf("char %h last %b with nothing pending", ch, last));
    end else begin
      want = pending.pop_front();
      if (ch !== want.ch) report($sformatf("char %h, wanted %h", ch, want.ch));
      if (last !== want.last) report($sformatf("last %b, wanted %b on char %h", last, want.last, ch));
    end
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_REQUESTS = 480;
  localparam int TAIL_CYCLES = 200;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic is_negative;
  logic [ntr_pkg::INT_W-1:0] integer_magnitude;
  logic [ntr_pkg::FRAC_IN_W-1:0] fraction_magnitude;
  logic [ntr_pkg::RADIX_W-1:0] radix;
  logic signed_mode;
  logic [ntr_pkg::NDIG_W-1:0] frac_digits;
  logic empty;
  logic pop;
  logic [ntr_pkg::CHAR_W-1:0] char_out;
  logic last_char;

  text_scoreboard sb;
  logic no_idle;
  int unsigned cycles;

  number_to_radix_text DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .is_negative(is_negative),
    .integer_magnitude(integer_magnitude),
    .fraction_magnitude(fraction_magnitude),
    .radix(radix),
    .signed_mode(signed_mode),
    .frac_digits(frac_digits),
    .empty(empty),
    .pop(pop),
    .char_out(char_out),
    .last_char(last_char)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(input logic neg, input logic [31:0] ip, input logic [31:0] fr,
                              input logic [4:0] rdx, input logic sgn, input logic [3:0] nd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    is_negative <= neg;
    integer_magnitude <= ip;
    fraction_magnitude <= fr;
    radix <= rdx;
    signed_mode <= sgn;
    frac_digits <= nd;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(neg, ip, fr, rdx, sgn, nd);
  endtask

  task automatic send_random();
    logic [31:0] ip;
    logic [31:0] fr;
    logic [4:0] rdx;
    case ($urandom_range(0, 5))
      0: ip = 32'd0;
      1: ip = $urandom_range(0, 15);
      2: ip = $urandom_range(0, 1000);
      3: ip = 32'hFFFF_FFFF;
      default: ip = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: fr = 32'd0;
      1: fr = 32'd1 << $urandom_range(0, 31);
      2: fr = 32'hFFFF_FFFF;
      3: fr = $urandom & 32'hFFFF_0000;
      default: fr = $urandom;
    endcase
    if ($urandom_range(0, 7) == 0) rdx = 5'($urandom_range(0, 31));
    else rdx = 5'($urandom_range(2, 16));
    send_request(1'($urandom_range(0, 1)), ip, fr, rdx, 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)));
  endtask

  task automatic drain_text();
    int gap;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      sb.check_result(char_out, last_char);
    end
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    is_negative = 1'b0;
    integer_magnitude = '0;
    fraction_magnitude = '0;
    radix = 5'd10;
    signed_mode = 1'b0;
    frac_digits = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_text();
    join_none

    // directed corners
    send_request(1'b0, 32'd0, 32'd0, 5'd10, 1'b1, 4'd0);
    send_request(1'b1, 32'd0, 32'd0, 5'd10, 1'b0, 4'd3);
    send_request(1'b1, 32'd0, 32'd0, 5'd16, 1'b1, 4'd15);
    send_request(1'b1, 32'd123, 32'd0, 5'd10, 1'b0, 4'd4);
    send_request(1'b1, 32'd0, 32'h0000_0001, 5'd10, 1'b0, 4'd2);
    send_request(1'b1, 32'd0, 32'h8000_0000, 5'd10, 1'b1, 4'd15);
    send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2, 1'b1, 4'd15);
    send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16, 1'b0, 4'd15);
    send_request(1'b0, 32'hFFFF_FFFF, 32'd0, 5'd10, 1'b1, 4'd15);
    send_request(1'b0, 32'd12345, 32'd0, 5'd0, 1'b1, 4'd3);
    send_request(1'b0, 32'd12345, 32'h4000_0000, 5'd1, 1'b0, 4'd5);
    send_request(1'b0, 32'd12345, 32'h4000_0000, 5'd17, 1'b0, 4'd5);
    send_request(1'b0, 32'd12345, 32'hC000_0000, 5'd31, 1'b1, 4'd8);
    send_request(1'b0, 32'd7, 32'h5555_5555, 5'd3, 1'b1, 4'd15);
    send_request(1'b0, 32'd36, 32'h1234_5678, 5'd8, 1'b1, 4'd1);
    send_request(1'b1, 32'd1, 32'hFFFF_FFFF, 5'd10, 1'b1, 4'd15);
    send_request(1'b0, 32'd255, 32'h0000_0001, 5'd4, 1'b1, 4'd15);
    send_request(1'b0, 32'hFFFF_FFFF, 32'hABCD_EF01, 5'd7, 1'b0, 4'd9);
    send_request(1'b1, 32'd0, 32'h0000_0001, 5'd5, 1'b1, 4'd15);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_random();
    end
    push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/ntr_pkg.sv
rtl/ntr_front.sv
rtl/ntr_back.sv
rtl/ntr_outq.sv
rtl/number_to_radix_text.sv
verif/tb.sv
